/* sv/bgsc_pkg.sv */
// ----------------------------------------------------------------------------
// bgsc_pkg
// Shared types and constants of the binary grid speckle cleaner.
// ----------------------------------------------------------------------------
package bgsc_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int WIDTH_FIELD_W = 11;
    localparam int HEIGHT_W    = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

    // window: four rows of four cells, newest cell at index 0
    localparam int CHAIN_LEN = 16;

    // window taps, named by offset from the visited cell (w = grid width)
    localparam int TAP_2W_P2 = 0;
    localparam int TAP_2W_P1 = 1;
    localparam int TAP_2W    = 2;
    localparam int TAP_2W_M1 = 3;
    localparam int TAP_W_P2  = 4;
    localparam int TAP_W_P1  = 5;
    localparam int TAP_W     = 6;
    localparam int TAP_W_M1  = 7;
    localparam int TAP_P2    = 8;
    localparam int TAP_P1    = 9;
    localparam int TAP_0     = 10;
    localparam int TAP_M1    = 11;
    localparam int TAP_MW_P2 = 12;
    localparam int TAP_MW_P1 = 13;
    localparam int TAP_MW    = 14;
    localparam int TAP_MW_M1 = 15;

    typedef struct packed {
        logic shift;
        logic flip;
    } t_cell_ctl;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_gap_ctl;

endpackage

/* sv/binary_grid_speckle_cleaner_unit.sv */
// ----------------------------------------------------------------------------
// binary_grid_speckle_cleaner_unit
// Raster-order speckle cleaner for a one-bit occupancy grid.
// ----------------------------------------------------------------------------
// The block takes one grid cell and gives one cleaned cell per clock once
// primed, unless the output stalls; the cleaned grid comes out in raster order
// 2*width+2 requests behind the input, so the host appends that many padding
// requests after each grid. A visit waits in the pending register and its
// result is registered for output. The neighborhood is a chain of sixteen
// cells (four rows of four) joined by three line delays of width-4 cells, each
// a RAM of MAX_WIDTH-4 entries; the visit of one cell and the shift of the
// chain share a single cycle, which sets the rate at one request per clock. No
// clear pass is needed after reset. A register write restarts the grid.
module binary_grid_speckle_cleaner_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [bgsc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [bgsc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_cell_in,
    input  logic                             i_is_padding,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_cell_out,
    output logic                             o_last_cell
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int HW = bgsc_pkg::HEIGHT_W;
    localparam int NC = bgsc_pkg::CHAIN_LEN;
    localparam int WIDTH_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

    // configuration
    logic [WW-1:0] r_width;
    logic [HW-1:0] r_height;
    logic [WW-1:0] n_width;
    logic [HW-1:0] n_height;
    logic [15:0]   wr_w;
    logic [WW:0]   w_ext;

    // input side position
    logic [CW-1:0] r_in_col,  n_in_col,  eff_col;
    logic [HW-1:0] r_in_row,  n_in_row,  eff_row;
    logic          r_in_done, n_in_done, eff_done;

    // visit side position
    logic [CW-1:0] r_col, n_col;
    logic [HW-1:0] r_row, n_row;
    logic [WW:0]   col_ext;

    logic r_pend, n_pend;
    logic r_pend_emit, n_pend_emit;
    logic r_out_valid, n_out_valid;
    logic r_out_cell,  n_out_cell;
    logic r_out_last,  n_out_last;

    logic acc, can_out, visit_go, last, restart_now;
    logic new_emit, new_cell;
    logic inner, ring_fit, f0, c, big;
    logic [NC-1:0] q, fwd, din, flip;
    logic gap2_out, gap1_out, gap0_out;
    logic [WW-1:0] gap_len;
    bgsc_pkg::t_cell_ctl cell_ctl [NC];
    bgsc_pkg::t_gap_ctl  gap_ctl;

    assign w_ext   = (WW+1)'(r_width);
    assign col_ext = (WW+1)'(r_col);

    // configuration writes with clamping
    assign wr_w = {5'd0, i_cfg_wdata[bgsc_pkg::WIDTH_FIELD_W-1:0]};

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                bgsc_pkg::CFG_GRID_WIDTH: begin
                    if (wr_w < 16'd3) begin
                        n_width = WW'(3);
                    end else if (wr_w > 16'(MAX_WIDTH)) begin
                        n_width = WW'(MAX_WIDTH);
                    end else begin
                        n_width = WW'(wr_w);
                    end
                end
                bgsc_pkg::CFG_GRID_HEIGHT: begin
                    n_height = (i_cfg_wdata < 16'd3) ? HW'(3) : i_cfg_wdata;
                end
                default: begin
                    n_width  = r_width;
                    n_height = r_height;
                end
            endcase
        end
    end

    // handshake
    assign can_out    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_pend || !r_pend_emit || can_out;
    assign acc        = i_in_valid && o_in_ready;
    assign visit_go   = r_pend && r_pend_emit && can_out;
    assign last       = (r_row == r_height - HW'(1)) && (col_ext + (WW+1)'(1) == w_ext);
    assign restart_now = visit_go && last;

    // position of the incoming request, counted from the new grid on restart
    assign eff_col  = restart_now ? '0 : r_in_col;
    assign eff_row  = restart_now ? '0 : r_in_row;
    assign eff_done = restart_now ? 1'b0 : r_in_done;

    assign new_emit = eff_done || (eff_row > HW'(2)) ||
                      ((eff_row == HW'(2)) && (eff_col >= CW'(2)));
    assign new_cell = !eff_done && !i_is_padding && i_cell_in;

    always_comb begin
        n_in_col  = eff_col;
        n_in_row  = eff_row;
        n_in_done = eff_done;
        if (acc && !eff_done) begin
            if ((WW+1)'(eff_col) + (WW+1)'(1) == w_ext) begin
                n_in_col = '0;
                if (eff_row + HW'(1) == r_height) begin
                    n_in_done = 1'b1;
                end else begin
                    n_in_row = eff_row + HW'(1);
                end
            end else begin
                n_in_col = eff_col + CW'(1);
            end
        end
        if (i_cfg_wr_en) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_in_done = 1'b0;
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (visit_go) begin
            if (last) begin
                n_col = '0;
                n_row = '0;
            end else if (col_ext + (WW+1)'(1) == w_ext) begin
                n_col = '0;
                n_row = r_row + HW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
        if (i_cfg_wr_en) begin
            n_col = '0;
            n_row = '0;
        end
    end

    always_comb begin
        n_pend      = r_pend;
        n_pend_emit = r_pend_emit;
        if (acc) begin
            n_pend      = 1'b1;
            n_pend_emit = new_emit;
        end else if (r_pend && (!r_pend_emit || can_out)) begin
            n_pend = 1'b0;
        end
    end

    // visit of the cell at the center tap
    always_comb begin
        inner = (r_row != '0) && ((HW+1)'(r_row) + (HW+1)'(2) <= (HW+1)'(r_height)) &&
                (r_col != '0) && (col_ext + (WW+1)'(2) <= w_ext);
        ring_fit = ((HW+1)'(r_row) + (HW+1)'(3) <= (HW+1)'(r_height)) &&
                   (col_ext + (WW+1)'(3) <= w_ext);
        f0  = inner && (q[bgsc_pkg::TAP_0] != q[bgsc_pkg::TAP_M1]) &&
              (q[bgsc_pkg::TAP_0] != q[bgsc_pkg::TAP_P1]);
        c   = q[bgsc_pkg::TAP_0] ^ f0;
        big = inner && (q[bgsc_pkg::TAP_0] != q[bgsc_pkg::TAP_M1]) && ring_fit &&
              (c == q[bgsc_pkg::TAP_P1]) && (c == q[bgsc_pkg::TAP_W]) &&
              (c == q[bgsc_pkg::TAP_W_P1]) &&
              (c != q[bgsc_pkg::TAP_MW_M1]) && (c != q[bgsc_pkg::TAP_MW]) &&
              (c != q[bgsc_pkg::TAP_MW_P1]) && (c != q[bgsc_pkg::TAP_MW_P2]) &&
              (c != q[bgsc_pkg::TAP_P2]) && (c != q[bgsc_pkg::TAP_W_P2]) &&
              (c != q[bgsc_pkg::TAP_2W_P2]) && (c != q[bgsc_pkg::TAP_2W_P1]) &&
              (c != q[bgsc_pkg::TAP_2W]) && (c != q[bgsc_pkg::TAP_2W_M1]) &&
              (c != q[bgsc_pkg::TAP_W_M1]);
        flip = '0;
        if (visit_go) begin
            flip[bgsc_pkg::TAP_0]    = f0 ^ big;
            flip[bgsc_pkg::TAP_P1]   = big;
            flip[bgsc_pkg::TAP_W]    = big;
            flip[bgsc_pkg::TAP_W_P1] = big;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_cell  = r_out_cell;
        n_out_last  = r_out_last;
        if (visit_go) begin
            n_out_valid = 1'b1;
            n_out_cell  = fwd[bgsc_pkg::TAP_0];
            n_out_last  = last;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= WW'(WIDTH_RST);
            r_height    <= HW'(1024);
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_in_done   <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_pend      <= 1'b0;
            r_pend_emit <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_width     <= n_width;
            r_height    <= n_height;
            r_in_col    <= n_in_col;
            r_in_row    <= n_in_row;
            r_in_done   <= n_in_done;
            r_col       <= n_col;
            r_row       <= n_row;
            r_pend      <= n_pend;
            r_pend_emit <= n_pend_emit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_cell <= n_out_cell;
        r_out_last <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_cell_out  = r_out_cell;
    assign o_last_cell = r_out_last;

    // window chain; row heads are fed by the line delays, or straight from
    // the row above when the rows touch or overlap
    assign gap_len       = r_width - WW'(4);
    assign gap_ctl.shift = acc;
    assign gap_ctl.clear = i_cfg_wr_en;

    always_comb begin
        din = {fwd[NC-2:0], new_cell};
        if (r_width == WW'(3)) begin
            din[4]  = fwd[2];
            din[8]  = fwd[6];
            din[12] = fwd[10];
        end else if (r_width == WW'(4)) begin
            din[4]  = fwd[3];
            din[8]  = fwd[7];
            din[12] = fwd[11];
        end else begin
            din[4]  = gap2_out;
            din[8]  = gap1_out;
            din[12] = gap0_out;
        end
    end

    for (genvar k = 0; k < NC; k++) begin : g_cell
        assign cell_ctl[k].shift = acc;
        assign cell_ctl[k].flip  = flip[k];
        bgsc_cell u_cell (
            .i_clk (i_clk),
            .i_ctl (cell_ctl[k]),
            .i_din (din[k]),
            .o_q   (q[k]),
            .o_fwd (fwd[k])
        );
    end

    bgsc_gap #(.MAX_WIDTH(MAX_WIDTH)) u_gap2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (gap_ctl),
        .i_len   (gap_len),
        .i_din   (fwd[3]),
        .o_dout  (gap2_out)
    );

    bgsc_gap #(.MAX_WIDTH(MAX_WIDTH)) u_gap1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (gap_ctl),
        .i_len   (gap_len),
        .i_din   (fwd[7]),
        .o_dout  (gap1_out)
    );

    bgsc_gap #(.MAX_WIDTH(MAX_WIDTH)) u_gap0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (gap_ctl),
        .i_len   (gap_len),
        .i_din   (fwd[11]),
        .o_dout  (gap0_out)
    );

    // end of grid brings the visit position home
    a_restart_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        restart_now |=> (r_row == '0) && (r_col == '0))
        else $error("visit position not cleared after last cell");

    // a pending visit always lies inside the grid
    a_visit_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && r_pend_emit) |-> (r_row < r_height))
        else $error("visit row beyond grid height");

    // past the grid the input row counter parks on the last row
    a_done_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_done |-> (r_in_row == r_height - HW'(1)))
        else $error("input row counter moved past last row");

endmodule

/* sv/bgsc_ram.sv */
// ----------------------------------------------------------------------------
// bgsc_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module bgsc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/bgsc_cell.sv */
// ----------------------------------------------------------------------------
// bgsc_cell
// One window cell: holds a grid bit, applies a flip, hands it to its neighbor.
// ----------------------------------------------------------------------------
module bgsc_cell (
    input  logic                i_clk,
    input  bgsc_pkg::t_cell_ctl i_ctl,
    input  logic                i_din,
    output logic                o_q,
    output logic                o_fwd
);

    logic r_q;
    logic n_q;

    // flipped value moves on with the shift
    assign o_fwd = r_q ^ i_ctl.flip;
    assign n_q   = i_ctl.shift ? i_din : o_fwd;
    assign o_q   = r_q;

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

endmodule

/* sv/bgsc_gap.sv */
// ----------------------------------------------------------------------------
// bgsc_gap
// Variable line delay between two window rows, length grid width minus four.
// ----------------------------------------------------------------------------
module bgsc_gap #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bgsc_pkg::t_gap_ctl             i_ctl,
    input  logic [$clog2(MAX_WIDTH+1)-1:0] i_len,
    input  logic                           i_din,
    output logic                           o_dout
);

    localparam int DEPTH = (MAX_WIDTH > 6) ? MAX_WIDTH - 4 : 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(MAX_WIDTH + 1);

    logic [AW-1:0] r_ptr;
    logic [AW-1:0] n_ptr;
    logic [LW:0]   ptr_inc;
    logic          ram_q;
    logic          r_byp;

    assign ptr_inc = (LW+1)'(r_ptr) + (LW+1)'(1);
    // read the slot that is oldest at the next shift
    assign n_ptr   = (ptr_inc >= {1'b0, i_len}) ? '0 : AW'(ptr_inc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (i_ctl.clear) begin
            r_ptr <= '0;
        end else if (i_ctl.shift) begin
            r_ptr <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_byp <= i_din;
        end
    end

    bgsc_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.shift),
        .i_waddr (r_ptr),
        .i_wdata (i_din),
        .i_re    (i_ctl.shift),
        .i_raddr (n_ptr),
        .o_rdata (ram_q)
    );

    // a one-cell delay is a single register
    assign o_dout = (i_len == LW'(1)) ? r_byp : ram_q;

endmodule
